>>> sv/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared shorthand for the concurrent checks in the RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property checked on every rising edge outside reset.
`define TETL_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// An implication in the same cycle, checked outside reset.
`define TETL_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

>>> sv/tetl_pkg.sv
// ----------------------------------------------------------------------------
// Timed event table lookup package
// Sizes, codes and the stored event format shared by the block.
// ----------------------------------------------------------------------------
package tetl_pkg;

    localparam int TRACKS           = 4;
    localparam int EVENTS_PER_TRACK = 1024;

    localparam int TRK_W     = (TRACKS > 1) ? $clog2(TRACKS) : 1;
    localparam int TRK_SLOTS = 2 ** TRK_W;
    localparam int EV_W      = $clog2(EVENTS_PER_TRACK);
    localparam int FILL_W    = $clog2(EVENTS_PER_TRACK + 1);
    localparam int ADDR_W    = TRK_W + EV_W;
    localparam int MEM_DEPTH = 2 ** ADDR_W;

    localparam int TIME_W  = 32;
    localparam int NOTE_W  = 7;
    localparam int PITCH_W = 8;
    localparam int VEL_W   = 7;
    localparam int COUNT_W = 11;
    localparam int PAY_W   = TIME_W + PITCH_W + VEL_W;

    localparam logic signed [PITCH_W-1:0] PITCH_BASE = 8'sd60;
    localparam logic signed [PITCH_W-1:0] EMPTY_LOW  = -8'sd12;
    localparam logic signed [PITCH_W-1:0] EMPTY_HIGH = 8'sd12;
    localparam logic signed [PITCH_W-1:0] PITCH_ONE  = 8'sd1;

    typedef enum logic [1:0] {
        MODE_CLEAR  = 2'd0,
        MODE_APPEND = 2'd1,
        MODE_QUERY  = 2'd2
    } t_mode;

    typedef enum logic [1:0] {
        STAT_OK    = 2'd0,
        STAT_FULL  = 2'd1,
        STAT_ORDER = 2'd2
    } t_status;

    // Everything of an event except its start time, which has a memory of its own.
    typedef struct packed {
        logic [TIME_W-1:0]         length;
        logic signed [PITCH_W-1:0] pitch;
        logic [VEL_W-1:0]          velocity;
    } t_payload;

endpackage

>>> sv/tetl_ram.sv
// ----------------------------------------------------------------------------
// Generic synchronous RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module tetl_ram #(
    parameter int  WIDTH = 8,
    parameter int  DEPTH = 16,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> sv/timed_event_table_lookup.sv
// ----------------------------------------------------------------------------
// Timed event table lookup
// Per-track note event tables with append, clear and time-indexed queries.
// ----------------------------------------------------------------------------
// Each beat on the input carries one command: clear every track, append an
// event to a track, or query a track at a time. Every beat gives exactly one
// result beat. The block works on one beat at a time. A clear, an append to
// a full track, an append to an empty track, an unused mode and a query of an
// empty track go from dispatch straight to the done state. Any other append
// first reads the previous start time back to check the order. A query
// binary-searches the start-time memory with one probe per cycle, as that
// memory has a single read port; a full track holds 1024 events. A new beat
// is taken in the cycle after its result has moved to the output register. A
// result may wait there while the next command runs. A command that finishes
// while the result before it is still waiting holds until that result is
// taken. The event stores need no clearing pass, because only entries below a
// track's fill count are ever read.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module timed_event_table_lookup
    import tetl_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,

    input  logic                      i_valid,
    output logic                      o_ready,
    input  logic [1:0]                i_mode,
    input  logic [1:0]                i_track,
    input  logic [TIME_W-1:0]         i_time_us,
    input  logic [TIME_W-1:0]         i_length_us,
    input  logic [NOTE_W-1:0]         i_note_pitch,
    input  logic [VEL_W-1:0]          i_note_velocity,

    output logic                      o_valid,
    input  logic                      i_ready,
    output logic [1:0]                o_status,
    output logic [COUNT_W-1:0]        o_events_before,
    output logic [TIME_W-1:0]         o_hit_start_us,
    output logic [TIME_W-1:0]         o_hit_length_us,
    output logic signed [PITCH_W-1:0] o_hit_pitch_shift,
    output logic [VEL_W-1:0]          o_hit_velocity,
    output logic                      o_sounding,
    output logic [COUNT_W-1:0]        o_track_items,
    output logic signed [PITCH_W-1:0] o_track_low,
    output logic signed [PITCH_W-1:0] o_track_high
);

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_DISP   = 5'b00010,
        S_APP_RD = 5'b00100,
        S_SEARCH = 5'b01000,
        S_DONE   = 5'b10000
    } t_state;

    t_state r_state, n_state;

    // Command held for the duration of its work.
    logic [1:0]          r_mode;
    logic [1:0]          r_track;
    logic [TIME_W-1:0]   r_time;
    logic [TIME_W-1:0]   r_length;
    logic [NOTE_W-1:0]   r_pitch;
    logic [VEL_W-1:0]    r_vel;

    // Per-track metadata, in flip-flops so that a clear resets every track at once.
    logic [FILL_W-1:0]         r_fill [TRK_SLOTS];
    logic signed [PITCH_W-1:0] r_low  [TRK_SLOTS];
    logic signed [PITCH_W-1:0] r_high [TRK_SLOTS];

    // Search window and probe.
    logic [FILL_W-1:0] r_lo, n_lo;
    logic [FILL_W-1:0] r_hi, n_hi;
    logic [FILL_W-1:0] r_mid, n_mid;

    // Last event found at or before the query time.
    logic [TIME_W-1:0] r_hit_start;
    t_payload          r_hit_pay;

    logic [1:0] r_status, n_status;
    logic       r_query, n_query;
    logic       r_empty, n_empty;

    // Output register.
    logic                      r_out_valid;
    logic [1:0]                r_o_status;
    logic [COUNT_W-1:0]        r_o_events_before;
    logic [TIME_W-1:0]         r_o_hit_start;
    logic [TIME_W-1:0]         r_o_hit_length;
    logic signed [PITCH_W-1:0] r_o_hit_pitch;
    logic [VEL_W-1:0]          r_o_hit_vel;
    logic                      r_o_playing;
    logic [COUNT_W-1:0]        r_o_items;
    logic signed [PITCH_W-1:0] r_o_min;
    logic signed [PITCH_W-1:0] r_o_max;

    // Memory ports.
    logic              w_we;
    logic [ADDR_W-1:0] w_waddr;
    logic [ADDR_W-1:0] w_raddr;
    logic [TIME_W-1:0] w_start_rd;
    logic [PAY_W-1:0]  w_pay_rd_bits;
    t_payload          w_pay_rd;
    t_payload          w_pay_wr;

    logic [TRK_W-1:0]          w_trk;
    logic                      w_in_range;
    logic [FILL_W-1:0]         w_fill;
    logic signed [PITCH_W-1:0] w_shift;
    logic signed [PITCH_W-1:0] w_low;
    logic signed [PITCH_W-1:0] w_high;

    logic              w_cmp;
    logic [FILL_W-1:0] w_lo_t;
    logic [FILL_W-1:0] w_mid_t;
    logic [FILL_W-1:0] w_mid_f;
    logic              w_more;
    logic              w_hit_load;
    logic              w_accept;
    logic              w_clear;
    logic              w_app_ok;
    logic              w_out_load;
    logic              w_playing;

    assign w_accept   = i_valid && o_ready;
    assign w_trk      = TRK_W'(r_track);
    assign w_in_range = 32'(r_track) < 32'(TRACKS);
    assign w_fill     = r_fill[w_trk];
    assign w_low      = r_low[w_trk];
    assign w_high     = r_high[w_trk];
    assign w_shift    = $signed({1'b0, r_pitch}) - PITCH_BASE;

    assign w_pay_wr.length   = r_length;
    assign w_pay_wr.pitch    = w_shift;
    assign w_pay_wr.velocity = r_vel;
    assign w_pay_rd          = t_payload'(w_pay_rd_bits);

    // The next event always lands at the track's fill position.
    assign w_waddr = {w_trk, w_fill[EV_W-1:0]};

    // Both possible next probes are worked out from the registered window, so
    // that the compare of the returning start time only has to pick one.
    assign w_cmp   = w_start_rd <= r_time;
    assign w_lo_t  = r_mid + FILL_W'(1);
    assign w_mid_t = w_lo_t + ((r_hi - w_lo_t) >> 1);
    assign w_mid_f = r_lo + ((r_mid - r_lo) >> 1);

    assign w_playing = (r_time - r_hit_start) < r_hit_pay.length;

    always_comb begin
        n_state    = r_state;
        n_lo       = r_lo;
        n_hi       = r_hi;
        n_mid      = r_mid;
        n_status   = r_status;
        n_query    = r_query;
        n_empty    = r_empty;
        w_we       = 1'b0;
        w_raddr    = {w_trk, w_fill[EV_W-1:0] - EV_W'(1)};
        w_clear    = 1'b0;
        w_app_ok   = 1'b0;
        w_hit_load = 1'b0;
        w_more     = 1'b0;
        w_out_load = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_state = S_DISP;
                end
            end
            S_DISP: begin
                n_status = STAT_OK;
                n_query  = 1'b0;
                n_empty  = 1'b0;
                n_state  = S_DONE;
                unique case (r_mode)
                    MODE_CLEAR: begin
                        w_clear = 1'b1;
                    end
                    MODE_APPEND: begin
                        if (!w_in_range || w_fill >= FILL_W'(EVENTS_PER_TRACK)) begin
                            n_status = STAT_FULL;
                        end else if (w_fill == '0) begin
                            w_we     = 1'b1;
                            w_app_ok = 1'b1;
                        end else begin
                            // Read back the last start time for the order check.
                            n_state = S_APP_RD;
                        end
                    end
                    MODE_QUERY: begin
                        if (!w_in_range || w_fill == '0) begin
                            n_empty = 1'b1;
                        end else begin
                            n_query = 1'b1;
                            n_lo    = '0;
                            n_hi    = w_fill;
                            n_mid   = w_fill >> 1;
                            w_raddr = {w_trk, n_mid[EV_W-1:0]};
                            n_state = S_SEARCH;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            S_APP_RD: begin
                n_state = S_DONE;
                if (r_time < w_start_rd) begin
                    n_status = STAT_ORDER;
                end else begin
                    w_we     = 1'b1;
                    w_app_ok = 1'b1;
                end
            end
            S_SEARCH: begin
                if (w_cmp) begin
                    w_hit_load = 1'b1;
                    n_lo       = w_lo_t;
                    n_mid      = w_mid_t;
                    w_more     = w_lo_t < r_hi;
                end else begin
                    n_hi   = r_mid;
                    n_mid  = w_mid_f;
                    w_more = r_lo < r_mid;
                end
                w_raddr = {w_trk, n_mid[EV_W-1:0]};
                if (!w_more) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (!r_out_valid || i_ready) begin
                    w_out_load = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control state and track metadata.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_status    <= STAT_OK;
            r_query     <= 1'b0;
            r_empty     <= 1'b0;
            r_out_valid <= 1'b0;
            for (int i = 0; i < TRK_SLOTS; i++) begin
                r_fill[i] <= '0;
                r_low[i]  <= '0;
                r_high[i] <= '0;
            end
        end else begin
            r_state  <= n_state;
            r_status <= n_status;
            r_query  <= n_query;
            r_empty  <= n_empty;
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
            if (w_clear) begin
                for (int i = 0; i < TRK_SLOTS; i++) begin
                    r_fill[i] <= '0;
                    r_low[i]  <= '0;
                    r_high[i] <= '0;
                end
            end else if (w_app_ok) begin
                r_fill[w_trk] <= w_fill + FILL_W'(1);
                if (w_fill == '0 || w_shift < w_low) begin
                    r_low[w_trk] <= w_shift;
                end
                if (w_fill == '0 || w_shift > w_high) begin
                    r_high[w_trk] <= w_shift;
                end
            end
        end
    end

    // Data path registers.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_mode   <= i_mode;
            r_track  <= i_track;
            r_time   <= i_time_us;
            r_length <= i_length_us;
            r_pitch  <= i_note_pitch;
            r_vel    <= i_note_velocity;
        end
        r_lo  <= n_lo;
        r_hi  <= n_hi;
        r_mid <= n_mid;
        if (r_state == S_DISP) begin
            r_hit_start <= '0;
            r_hit_pay   <= '0;
        end else if (w_hit_load) begin
            r_hit_start <= w_start_rd;
            r_hit_pay   <= w_pay_rd;
        end
        if (w_out_load) begin
            r_o_status        <= r_status;
            r_o_events_before <= '0;
            r_o_hit_start     <= '0;
            r_o_hit_length    <= '0;
            r_o_hit_pitch     <= '0;
            r_o_hit_vel       <= '0;
            r_o_playing       <= 1'b0;
            r_o_items         <= '0;
            r_o_min           <= '0;
            r_o_max           <= '0;
            if (r_query) begin
                r_o_events_before <= COUNT_W'(r_lo);
                r_o_hit_start     <= r_hit_start;
                r_o_hit_length    <= r_hit_pay.length;
                r_o_hit_pitch     <= r_hit_pay.pitch;
                r_o_hit_vel       <= r_hit_pay.velocity;
                r_o_playing       <= w_playing;
                r_o_items         <= COUNT_W'(w_fill);
                // A track of one pitch is widened by a semitone each way.
                if (w_low == w_high) begin
                    r_o_min <= w_low - PITCH_ONE;
                    r_o_max <= w_high + PITCH_ONE;
                end else begin
                    r_o_min <= w_low;
                    r_o_max <= w_high;
                end
            end else if (r_empty) begin
                r_o_min <= EMPTY_LOW;
                r_o_max <= EMPTY_HIGH;
            end
        end
    end

    tetl_ram #(
        .WIDTH (TIME_W),
        .DEPTH (MEM_DEPTH)
    ) u_start_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (r_time),
        .i_raddr (w_raddr),
        .o_rdata (w_start_rd)
    );

    tetl_ram #(
        .WIDTH (PAY_W),
        .DEPTH (MEM_DEPTH)
    ) u_payload_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_pay_wr),
        .i_raddr (w_raddr),
        .o_rdata (w_pay_rd_bits)
    );

    assign o_ready           = (r_state == S_IDLE);
    assign o_valid           = r_out_valid;
    assign o_status          = r_o_status;
    assign o_events_before   = r_o_events_before;
    assign o_hit_start_us    = r_o_hit_start;
    assign o_hit_length_us   = r_o_hit_length;
    assign o_hit_pitch_shift = r_o_hit_pitch;
    assign o_hit_velocity    = r_o_hit_vel;
    assign o_sounding        = r_o_playing;
    assign o_track_items     = r_o_items;
    assign o_track_low       = r_o_min;
    assign o_track_high      = r_o_max;

    `TETL_ASSERT_IMPL(a_search_window, i_clk, i_rst_n, r_state == S_SEARCH, (r_lo <= r_mid && r_mid < r_hi), "probe outside search window")
    `TETL_ASSERT_IMPL(a_write_state, i_clk, i_rst_n, w_we, (r_state == S_DISP || r_state == S_APP_RD), "event memory written outside an append")
    `TETL_ASSERT_IMPL(a_fill_bound, i_clk, i_rst_n, r_state != S_IDLE, w_fill <= FILL_W'(EVENTS_PER_TRACK), "track fill beyond capacity")
    `TETL_ASSERT(a_accept_dispatch, i_clk, i_rst_n, w_accept |=> (r_state == S_DISP), "accepted beat not dispatched")
    `TETL_ASSERT(a_result_held, i_clk, i_rst_n, (r_state == S_DONE && r_out_valid && !i_ready) |=> (r_state == S_DONE), "result overwrote a waiting beat")

endmodule

>>> tb/tetl_lookup_checker.sv
// ----------------------------------------------------------------------------
// Timed event table lookup checker
// Watches both channels of the block and keeps its own copy of the event
// tables. Each accepted command beat is turned into the answer the block
// should give; each result beat is compared field by field with the oldest
// answer still waiting.
// ----------------------------------------------------------------------------
module tetl_lookup_checker
    import tetl_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,

    input  logic                      i_cmd_valid,
    input  logic                      i_cmd_ready,
    input  logic [1:0]                i_mode,
    input  logic [1:0]                i_track,
    input  logic [TIME_W-1:0]         i_time_us,
    input  logic [TIME_W-1:0]         i_length_us,
    input  logic [NOTE_W-1:0]         i_note_pitch,
    input  logic [VEL_W-1:0]          i_note_velocity,

    input  logic                      i_res_valid,
    input  logic                      i_res_ready,
    input  logic [1:0]                i_status,
    input  logic [COUNT_W-1:0]        i_events_before,
    input  logic [TIME_W-1:0]         i_hit_start_us,
    input  logic [TIME_W-1:0]         i_hit_length_us,
    input  logic signed [PITCH_W-1:0] i_hit_pitch_shift,
    input  logic [VEL_W-1:0]          i_hit_velocity,
    input  logic                      i_sounding,
    input  logic [COUNT_W-1:0]        i_track_items,
    input  logic signed [PITCH_W-1:0] i_track_low,
    input  logic signed [PITCH_W-1:0] i_track_high,

    output int                        o_fail_count,
    output int                        o_outstanding,
    output int                        o_answers_checked,
    output int                        o_full_refusals,
    output int                        o_order_refusals,
    output int                        o_sounding_hits
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int PRINT_LIMIT = 40;

    typedef struct packed {
        logic [1:0]                status;
        logic [COUNT_W-1:0]        events_before;
        logic [TIME_W-1:0]         hit_start;
        logic [TIME_W-1:0]         hit_length;
        logic signed [PITCH_W-1:0] hit_pitch;
        logic [VEL_W-1:0]          hit_velocity;
        logic                      sounding;
        logic [COUNT_W-1:0]        track_items;
        logic signed [PITCH_W-1:0] track_low;
        logic signed [PITCH_W-1:0] track_high;
    } t_lookup_answer;

    // Shadow of the block's event tables.
    logic [TIME_W-1:0]         start_table    [TRACKS][EVENTS_PER_TRACK];
    logic [TIME_W-1:0]         length_table   [TRACKS][EVENTS_PER_TRACK];
    logic signed [PITCH_W-1:0] pitch_table    [TRACKS][EVENTS_PER_TRACK];
    logic [VEL_W-1:0]          velocity_table [TRACKS][EVENTS_PER_TRACK];
    int                        fill_level     [TRACKS];
    logic signed [PITCH_W-1:0] low_shift      [TRACKS];
    logic signed [PITCH_W-1:0] high_shift     [TRACKS];

    t_lookup_answer pending_answers[$];

    int fail_count      = 0;
    int answers_checked = 0;
    int full_refusals   = 0;
    int order_refusals  = 0;
    int sounding_hits   = 0;

    task automatic report_mismatch(input string msg);
        fail_count++;
        if (fail_count <= PRINT_LIMIT) begin
            $display("MISMATCH at %0t ns: %s", $time, msg);
        end
    endtask

    task automatic check_field(input string name, input logic [TIME_W-1:0] got,
                               input logic [TIME_W-1:0] want);
        if (got !== want) begin
            report_mismatch($sformatf("result %0d, %s is %0h, expected %0h",
                                      answers_checked, name, got, want));
        end
    endtask

    // Applies one command to the shadow tables and returns the answer it earns.
    function automatic t_lookup_answer predict_lookup(
        input logic [1:0]        mode,
        input logic [1:0]        trk,
        input logic [TIME_W-1:0] t,
        input logic [TIME_W-1:0] len,
        input logic [NOTE_W-1:0] pitch,
        input logic [VEL_W-1:0]  vel
    );
        t_lookup_answer            ans;
        int                        n;
        int                        lo;
        int                        hi;
        int                        mid;
        logic signed [PITCH_W-1:0] shift;
        logic [TIME_W-1:0]         since_start;

        ans = '0;
        case (mode)
            MODE_CLEAR: begin
                for (int k = 0; k < TRACKS; k++) begin
                    fill_level[k] = 0;
                    low_shift[k]  = '0;
                    high_shift[k] = '0;
                end
            end
            MODE_APPEND: begin
                n = (int'(trk) < TRACKS) ? fill_level[trk] : 0;
                if (int'(trk) >= TRACKS || n >= EVENTS_PER_TRACK) begin
                    ans.status = STAT_FULL;
                    full_refusals++;
                end else if (n > 0 && t < start_table[trk][n-1]) begin
                    ans.status = STAT_ORDER;
                    order_refusals++;
                end else begin
                    shift = signed'({1'b0, pitch}) - PITCH_BASE;
                    start_table[trk][n]    = t;
                    length_table[trk][n]   = len;
                    pitch_table[trk][n]    = shift;
                    velocity_table[trk][n] = vel;
                    if (n == 0 || shift < low_shift[trk]) low_shift[trk] = shift;
                    if (n == 0 || shift > high_shift[trk]) high_shift[trk] = shift;
                    fill_level[trk] = n + 1;
                    ans.status = STAT_OK;
                end
            end
            MODE_QUERY: begin
                if (int'(trk) >= TRACKS || fill_level[trk] == 0) begin
                    ans.track_low  = EMPTY_LOW;
                    ans.track_high = EMPTY_HIGH;
                end else begin
                    n  = fill_level[trk];
                    lo = 0;
                    hi = n;
                    // Count of events whose start is at or before the query time.
                    while (lo < hi) begin
                        mid = lo + (hi - lo) / 2;
                        if (start_table[trk][mid] <= t) lo = mid + 1;
                        else hi = mid;
                    end
                    ans.events_before = COUNT_W'(lo);
                    if (lo > 0) begin
                        ans.hit_start    = start_table[trk][lo-1];
                        ans.hit_length   = length_table[trk][lo-1];
                        ans.hit_pitch    = pitch_table[trk][lo-1];
                        ans.hit_velocity = velocity_table[trk][lo-1];
                        since_start      = t - ans.hit_start;
                        ans.sounding     = (since_start < ans.hit_length);
                        if (ans.sounding) sounding_hits++;
                    end
                    ans.track_items = COUNT_W'(n);
                    ans.track_low   = low_shift[trk];
                    ans.track_high  = high_shift[trk];
                    if (ans.track_low == ans.track_high) begin
                        ans.track_low  = ans.track_low - PITCH_ONE;
                        ans.track_high = ans.track_high + PITCH_ONE;
                    end
                end
            end
            default: begin
                // The unused mode leaves the tables alone and answers all zero.
            end
        endcase
        return ans;
    endfunction

    always @(posedge i_clk) begin
        t_lookup_answer want;
        if (!i_rst_n) begin
            pending_answers.delete();
            for (int k = 0; k < TRACKS; k++) begin
                fill_level[k] = 0;
                low_shift[k]  = '0;
                high_shift[k] = '0;
            end
        end else begin
            // Results are retired before new commands are predicted, so a stray
            // result can never be matched against an answer queued at this edge.
            if (i_res_valid && i_res_ready) begin
                if (pending_answers.size() == 0) begin
                    report_mismatch("result beat arrived with no answer waiting");
                end else begin
                    want = pending_answers.pop_front();
                    check_field("status", i_status, want.status);
                    check_field("events_before", i_events_before, want.events_before);
                    check_field("hit_start_us", i_hit_start_us, want.hit_start);
                    check_field("hit_length_us", i_hit_length_us, want.hit_length);
                    check_field("hit_pitch_shift", i_hit_pitch_shift, want.hit_pitch);
                    check_field("hit_velocity", i_hit_velocity, want.hit_velocity);
                    check_field("sounding", i_sounding, want.sounding);
                    check_field("track_items", i_track_items, want.track_items);
                    check_field("track_low", i_track_low, want.track_low);
                    check_field("track_high", i_track_high, want.track_high);
                    answers_checked++;
                end
            end
            if (i_cmd_valid && i_cmd_ready) begin
                pending_answers.insert(pending_answers.size(),
                                       predict_lookup(i_mode, i_track, i_time_us,
                                                      i_length_us, i_note_pitch,
                                                      i_note_velocity));
            end
        end
        o_fail_count      <= fail_count;
        o_outstanding     <= pending_answers.size();
        o_answers_checked <= answers_checked;
        o_full_refusals   <= full_refusals;
        o_order_refusals  <= order_refusals;
        o_sounding_hits   <= sounding_hits;
    end

endmodule

>>> tb/tb_timed_event_table_lookup.sv
// ----------------------------------------------------------------------------
// Timed event table lookup testbench
// Drives clear, append, query and unused-mode commands into the block with
// bursty traffic and a stalling receiver, while a checker alongside predicts
// and compares every result. A directed opening covers the corner cases, then
// a random mix over all tracks and finally a long fill of one track until it
// refuses appends for being full.
// ----------------------------------------------------------------------------
module tb_timed_event_table_lookup
    import tetl_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    // The mode encoding the block must ignore.
    localparam logic [1:0] MODE_UNUSED = 2'd3;

    // In a correct run the longest stretch with no beat moving is the
    // deliberate receiver hold-off plus one full-depth query.
    localparam int QUIET_LIMIT   = 2000;
    localparam int DRAIN_CYCLES  = 20;
    localparam int MIXED_BEATS   = 60;
    localparam int FULL_WANTED   = 12;
    localparam int FILL_GUARD    = 4000;
    localparam int HOLD_OFF      = 300;
    localparam int HOLD_TRIGGER  = 40;

    logic                      clk = 1'b0;
    logic                      rst_n = 1'b0;

    logic                      cmd_valid = 1'b0;
    logic                      cmd_ready;
    logic [1:0]                cmd_mode = MODE_CLEAR;
    logic [1:0]                cmd_track = '0;
    logic [TIME_W-1:0]         cmd_time = '0;
    logic [TIME_W-1:0]         cmd_length = '0;
    logic [NOTE_W-1:0]         cmd_pitch = '0;
    logic [VEL_W-1:0]          cmd_velocity = '0;

    logic                      res_valid;
    logic                      res_ready = 1'b0;
    logic [1:0]                res_status;
    logic [COUNT_W-1:0]        res_events_before;
    logic [TIME_W-1:0]         res_hit_start;
    logic [TIME_W-1:0]         res_hit_length;
    logic signed [PITCH_W-1:0] res_hit_pitch;
    logic [VEL_W-1:0]          res_hit_velocity;
    logic                      res_sounding;
    logic [COUNT_W-1:0]        res_track_items;
    logic signed [PITCH_W-1:0] res_track_low;
    logic signed [PITCH_W-1:0] res_track_high;

    int fail_count;
    int outstanding;
    int answers_checked;
    int full_refusals;
    int order_refusals;
    int sounding_hits;

    // Sender bookkeeping: the start time last appended to each track, so that
    // most appends stay in time order and queries land close to real events.
    logic [TIME_W-1:0] last_start [TRACKS];
    int                burst_left = 0;
    int                clears_sent = 0;
    int                appends_sent = 0;
    int                queries_sent = 0;
    int                unused_sent = 0;
    int                quiet_cycles = 0;

    always begin
        clk = 1'b1;
        #2;
        clk = 1'b0;
        #2;
    end

    timed_event_table_lookup dut (
        .i_clk             (clk),
        .i_rst_n           (rst_n),
        .i_valid           (cmd_valid),
        .o_ready           (cmd_ready),
        .i_mode            (cmd_mode),
        .i_track           (cmd_track),
        .i_time_us         (cmd_time),
        .i_length_us       (cmd_length),
        .i_note_pitch      (cmd_pitch),
        .i_note_velocity   (cmd_velocity),
        .o_valid           (res_valid),
        .i_ready           (res_ready),
        .o_status          (res_status),
        .o_events_before   (res_events_before),
        .o_hit_start_us    (res_hit_start),
        .o_hit_length_us   (res_hit_length),
        .o_hit_pitch_shift (res_hit_pitch),
        .o_hit_velocity    (res_hit_velocity),
        .o_sounding        (res_sounding),
        .o_track_items     (res_track_items),
        .o_track_low       (res_track_low),
        .o_track_high      (res_track_high)
    );

    tetl_lookup_checker checker_inst (
        .i_clk             (clk),
        .i_rst_n           (rst_n),
        .i_cmd_valid       (cmd_valid),
        .i_cmd_ready       (cmd_ready),
        .i_mode            (cmd_mode),
        .i_track           (cmd_track),
        .i_time_us         (cmd_time),
        .i_length_us       (cmd_length),
        .i_note_pitch      (cmd_pitch),
        .i_note_velocity   (cmd_velocity),
        .i_res_valid       (res_valid),
        .i_res_ready       (res_ready),
        .i_status          (res_status),
        .i_events_before   (res_events_before),
        .i_hit_start_us    (res_hit_start),
        .i_hit_length_us   (res_hit_length),
        .i_hit_pitch_shift (res_hit_pitch),
        .i_hit_velocity    (res_hit_velocity),
        .i_sounding        (res_sounding),
        .i_track_items     (res_track_items),
        .i_track_low       (res_track_low),
        .i_track_high      (res_track_high),
        .o_fail_count      (fail_count),
        .o_outstanding     (outstanding),
        .o_answers_checked (answers_checked),
        .o_full_refusals   (full_refusals),
        .o_order_refusals  (order_refusals),
        .o_sounding_hits   (sounding_hits)
    );

    // Offers one command beat and returns at the edge where it is accepted.
    // Beats go out in bursts; when a burst is used up, valid is dropped for a
    // random gap before the next one starts. A zero gap keeps valid high, so a
    // fresh burst can follow the last one without a bubble.
    task automatic send_beat(input logic [1:0] mode, input logic [1:0] trk,
                             input logic [TIME_W-1:0] t, input logic [TIME_W-1:0] len,
                             input logic [NOTE_W-1:0] pitch,
                             input logic [VEL_W-1:0] vel);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                cmd_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            // Now and then a long burst, so the block also sees back-to-back work.
            burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 60)
                                                      : $urandom_range(1, 12);
        end
        cmd_valid    <= 1'b1;
        cmd_mode     <= mode;
        cmd_track    <= trk;
        cmd_time     <= t;
        cmd_length   <= len;
        cmd_pitch    <= pitch;
        cmd_velocity <= vel;
        do @(posedge clk); while (!cmd_ready);
        burst_left--;
        case (mode)
            MODE_CLEAR:  clears_sent++;
            MODE_APPEND: appends_sent++;
            MODE_QUERY:  queries_sent++;
            default:     unused_sent++;
        endcase
    endtask

    // A clear carries random junk in its other fields; those must not matter.
    task automatic send_clear();
        send_beat(MODE_CLEAR, 2'($urandom_range(0, 3)), $urandom, $urandom,
                  7'($urandom_range(0, 127)), 7'($urandom_range(0, 127)));
        for (int k = 0; k < TRACKS; k++) last_start[k] = '0;
    endtask

    task automatic send_unused();
        send_beat(MODE_UNUSED, 2'($urandom_range(0, 3)), $urandom, $urandom,
                  7'($urandom_range(0, 127)), 7'($urandom_range(0, 127)));
    endtask

    // Lengths lean towards short notes, so that queries near a start often
    // find the event still sounding, with the extremes mixed in.
    function automatic logic [TIME_W-1:0] random_length();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick < 5) return $urandom_range(0, 2000);
        else if (pick < 8) return $urandom;
        else if (pick == 8) return '0;
        else return '1;
    endfunction

    // Appends an event at or after the track's last start. Small steps make
    // runs of equal start times; the sum saturates at the top of the range.
    task automatic append_in_order(input logic [1:0] trk);
        logic [TIME_W:0] sum;
        int              pick;
        pick = $urandom_range(0, 99);
        if (pick < 40) sum = last_start[trk] + $urandom_range(0, 3);
        else if (pick < 85) sum = last_start[trk] + $urandom_range(0, 5000);
        else sum = last_start[trk] + $urandom_range(0, 1 << 20);
        if (sum[TIME_W]) sum = {1'b0, {TIME_W{1'b1}}};
        last_start[trk] = sum[TIME_W-1:0];
        send_beat(MODE_APPEND, trk, sum[TIME_W-1:0], random_length(),
                  7'($urandom_range(0, 127)), 7'($urandom_range(0, 127)));
    endtask

    // Appends an event that starts strictly before the last one, which the
    // block refuses on a non-empty track; with a last start of zero it stays in order.
    task automatic append_out_of_order(input logic [1:0] trk);
        if (last_start[trk] == '0) begin
            append_in_order(trk);
        end else begin
            send_beat(MODE_APPEND, trk, $urandom_range(0, last_start[trk] - 1),
                      random_length(), 7'($urandom_range(0, 127)),
                      7'($urandom_range(0, 127)));
        end
    endtask

    // Queries mostly just below, across and just past the track's latest
    // start, and sometimes anywhere at all. The unused fields are random.
    task automatic query_near(input logic [1:0] trk);
        logic [TIME_W:0] t;
        int              pick;
        pick = $urandom_range(0, 99);
        if (pick < 40) begin
            t = (last_start[trk] > 50) ? last_start[trk] - $urandom_range(0, 50)
                                       : $urandom_range(0, 50);
        end else if (pick < 70) begin
            t = $urandom_range(0, last_start[trk]);
        end else if (pick < 85) begin
            t = last_start[trk] + $urandom_range(0, 3000);
            if (t[TIME_W]) t = {1'b0, {TIME_W{1'b1}}};
        end else begin
            t = $urandom;
        end
        send_beat(MODE_QUERY, trk, t[TIME_W-1:0], $urandom,
                  7'($urandom_range(0, 127)), 7'($urandom_range(0, 127)));
    endtask

    // Receiver: ready follows a stall pattern of its own. Most stretches are
    // short ready runs broken by short stalls, some are long runs with no
    // stall at all, and once, early on, ready is held low for a long time so
    // that the block's result register fills and its input stalls while the
    // sender keeps offering beats.
    initial begin
        bit held_off;
        held_off = 1'b0;
        do @(posedge clk); while (!rst_n);
        forever begin
            if (!held_off && answers_checked >= HOLD_TRIGGER) begin
                held_off = 1'b1;
                res_ready <= 1'b0;
                repeat (HOLD_OFF) @(posedge clk);
            end
            case ($urandom_range(0, 9))
                0: begin
                    res_ready <= 1'b1;
                    repeat (60) @(posedge clk);
                end
                1, 2, 3: begin
                    res_ready <= 1'b0;
                    repeat ($urandom_range(1, 6)) @(posedge clk);
                end
                default: begin
                    res_ready <= 1'b1;
                    repeat ($urandom_range(1, 12)) @(posedge clk);
                end
            endcase
        end
    end

    // Watchdog: ends the run if no beat moves on either channel for too long.
    always @(posedge clk) begin
        if ((cmd_valid && cmd_ready) || (res_valid && res_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("Watchdog: no beat moved for %0d cycles, %0d answers still due",
                     QUIET_LIMIT, outstanding);
            $display("CHECK FAILED");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        logic [1:0] fill_track;
        logic [1:0] trk;
        int         pick;
        int         fill_beats;

        for (int k = 0; k < TRACKS; k++) last_start[k] = '0;

        // Synchronous reset, held at the start and never asserted again.
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // ---- Directed opening ----
        // An empty track answers with the default pitch range and no hit.
        send_beat(MODE_QUERY, 2'd0, 32'd0, 32'd0, 7'd0, 7'd0);
        // A single event: its pitch shift is both minimum and maximum, so the
        // reported range is widened by one on each side.
        send_beat(MODE_APPEND, 2'd0, 32'd100, 32'd50, 7'd60, 7'd127);
        // Just before, exactly at, inside and just past the end of that event.
        send_beat(MODE_QUERY, 2'd0, 32'd99, 32'd0, 7'd0, 7'd0);
        send_beat(MODE_QUERY, 2'd0, 32'd100, 32'd0, 7'd0, 7'd0);
        send_beat(MODE_QUERY, 2'd0, 32'd149, 32'd0, 7'd0, 7'd0);
        send_beat(MODE_QUERY, 2'd0, 32'd150, 32'd0, 7'd0, 7'd0);
        // A start equal to the last start is accepted; an earlier one is not.
        send_beat(MODE_APPEND, 2'd0, 32'd100, 32'd0, 7'd0, 7'd0);
        send_beat(MODE_APPEND, 2'd0, 32'd99, 32'd10, 7'd30, 7'd30);
        // Largest time, length, pitch and velocity all at once.
        send_beat(MODE_APPEND, 2'd0, '1, '1, 7'd127, 7'd127);
        send_beat(MODE_QUERY, 2'd0, '1, '0, 7'd0, 7'd0);
        send_beat(MODE_QUERY, 2'd0, 32'd0, '1, 7'd127, 7'd127);
        // Lowest pitch alone on a track, and a zero-length note never sounds.
        send_beat(MODE_APPEND, 2'd1, 32'd0, 32'd0, 7'd0, 7'd1);
        send_beat(MODE_QUERY, 2'd1, 32'd0, 32'd0, 7'd0, 7'd0);
        // Highest pitch alone on a track, a one-microsecond note at bit 31.
        send_beat(MODE_APPEND, 2'd2, 32'h8000_0000, 32'd1, 7'd127, 7'd64);
        send_beat(MODE_QUERY, 2'd2, 32'h8000_0000, 32'd0, 7'd0, 7'd0);
        send_beat(MODE_QUERY, 2'd3, '1, '1, 7'd127, 7'd127);
        // The unused mode must answer all zero and leave track 0 untouched.
        send_beat(MODE_UNUSED, 2'd0, '1, '1, 7'd127, 7'd127);
        send_beat(MODE_QUERY, 2'd0, '1, '0, 7'd0, 7'd0);
        // After a clear the track is empty again, and an append earlier than
        // anything stored before the clear is in order.
        send_clear();
        send_beat(MODE_QUERY, 2'd0, '1, '0, 7'd0, 7'd0);
        send_beat(MODE_APPEND, 2'd0, 32'd5, 32'd5, 7'd61, 7'd2);
        send_beat(MODE_QUERY, 2'd0, 32'd7, 32'd0, 7'd0, 7'd0);
        send_clear();

        // ---- Random mix over all four tracks ----
        // Mostly in-order appends and queries, with refused appends, the odd
        // clear and some unused-mode noise.
        for (int i = 0; i < MIXED_BEATS; i++) begin
            trk  = 2'($urandom_range(0, 3));
            pick = $urandom_range(0, 99);
            if (pick < 3) send_clear();
            else if (pick < 6) send_unused();
            else if (pick < 50) append_in_order(trk);
            else if (pick < 56) append_out_of_order(trk);
            else query_near(trk);
        end

        // The sender stops here until every answer so far has come back.
        cmd_valid <= 1'b0;
        burst_left = 0;
        do @(posedge clk); while (outstanding != 0);

        // ---- Fill one track to capacity ----
        // Nearly all beats append to the chosen track in order, starting from
        // a random base, with queries probing ever deeper tables. The phase
        // ends once the full track has refused a dozen appends.
        send_clear();
        fill_track = 2'($urandom_range(0, 3));
        last_start[fill_track] = $urandom_range(0, 32'h7FFF_FFFF);
        fill_beats = 0;
        while (full_refusals < FULL_WANTED && fill_beats < FILL_GUARD) begin
            trk  = 2'($urandom_range(0, 3));
            pick = $urandom_range(0, 99);
            if (pick < 94) append_in_order(fill_track);
            else if (pick < 96) append_out_of_order(fill_track);
            else if (pick < 98) query_near(fill_track);
            else if (pick < 99) query_near(trk);
            else send_unused();
            fill_beats++;
        end

        // ---- Drain and verdict ----
        cmd_valid <= 1'b0;
        do @(posedge clk); while (outstanding != 0);
        // Run on so that any extra result beat would still be seen.
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Run covered %0d command beats: %0d clears, %0d appends, %0d queries, %0d unused.",
                 clears_sent + appends_sent + queries_sent + unused_sent,
                 clears_sent, appends_sent, queries_sent, unused_sent);
        $display("Appends refused: %0d on a full track, %0d out of order; %0d queries hit a sounding note.",
                 full_refusals, order_refusals, sounding_hits);
        if (fail_count == 0 && outstanding == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
